[hdl/itrt_pkg.sv]
`timescale 1ns / 1ps

package itrt_pkg;

  localparam int MaxDigits = 10;
  localparam int BufDepth  = MaxDigits + 1;
  localparam int IdxW      = $clog2(BufDepth);
  localparam int CntW      = $clog2(BufDepth + 1);
  localparam int ValueW    = 32;
  localparam int FormatW   = 5;
  localparam int CharW     = 8;
  localparam int BitCntW   = $clog2(ValueW);
  localparam int RemW      = 5;

  localparam logic [FormatW-1:0] FmtSignedDec = 5'd0;
  localparam logic [FormatW-1:0] FmtCharacter = 5'd1;
  localparam logic [FormatW-1:0] RadixLimit   = 5'd16;
  localparam logic [FormatW-1:0] SignedRadix  = 5'd10;
  localparam logic [CharW-1:0]   MinusChar    = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_SIGN,
    ST_EMIT
  } state_e;

  function automatic logic [CharW-1:0] digit_glyph(input logic [3:0] d);
    logic [CharW-1:0] g;
    case (d)
      4'd0:    g = 8'h30;
      4'd1:    g = 8'h31;
      4'd2:    g = 8'h32;
      4'd3:    g = 8'h33;
      4'd4:    g = 8'h34;
      4'd5:    g = 8'h35;
      4'd6:    g = 8'h36;
      4'd7:    g = 8'h37;
      4'd8:    g = 8'h38;
      4'd9:    g = 8'h39;
      4'd10:   g = 8'h41;
      4'd11:   g = 8'h42;
      4'd12:   g = 8'h43;
      4'd13:   g = 8'h44;
      4'd14:   g = 8'h45;
      default: g = 8'h46;
    endcase
    return g;
  endfunction

endpackage

[hdl/itrt_in_if.sv]
`timescale 1ns / 1ps

interface itrt_in_if;
  logic                          valid;
  logic                          ready;
  logic [itrt_pkg::ValueW-1:0]   value;
  logic [itrt_pkg::FormatW-1:0]  format;

  modport source (output valid, output value, output format, input ready);
  modport sink   (input valid, input value, input format, output ready);
endinterface

[hdl/itrt_out_if.sv]
`timescale 1ns / 1ps

interface itrt_out_if;
  logic                        valid;
  logic                        ready;
  logic [itrt_pkg::CharW-1:0]  text_char;
  logic                        last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink   (input valid, input text_char, input last, output ready);
endinterface

[hdl/integer_to_radix_text.sv]
`timescale 1ns / 1ps

// Channel   Dir   Payload                        Handshake
// in_i      in    value[31:0], format[4:0]       valid / ready
// out_o     out   text_char[7:0], last           valid / ready
//
// Each digit takes 32 steps of a shared bit-serial restoring divider, then its
// glyph is stored. An item runs the divider once per digit, adds a minus sign for a
// negative signed-decimal value, then emits one character per cycle while out_o is ready.
// A character item skips the divider, is stored directly and goes straight to emission.
// in_i is ready only while the sequencer is idle; a held output item never blocks it.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and clears out_o.valid.

module integer_to_radix_text (
  input  logic clk_i,
  input  logic rst_ni,
  itrt_in_if.sink    in_i,
  itrt_out_if.source out_o
);

  itrt_pkg::state_e state_q, state_d;

  logic [itrt_pkg::ValueW-1:0]  num_q, num_d;
  logic [itrt_pkg::RemW-1:0]    rem_q, rem_d;
  logic [itrt_pkg::FormatW-1:0] radix_q, radix_d;
  logic [itrt_pkg::BitCntW-1:0] bit_q, bit_d;
  logic [itrt_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [itrt_pkg::IdxW-1:0]    rd_q, rd_d;
  logic                         neg_q, neg_d;
  logic                         out_valid_q, out_valid_d;
  logic [itrt_pkg::CharW-1:0]   out_char_q, out_char_d;
  logic                         out_last_q, out_last_d;

  logic [itrt_pkg::CharW-1:0]   buf_q [itrt_pkg::BufDepth];
  logic                         buf_we;
  logic [itrt_pkg::IdxW-1:0]    buf_wa;
  logic [itrt_pkg::CharW-1:0]   buf_wd;

  logic                         in_acc;
  logic                         emit_go;
  logic                         more_digits;
  logic [itrt_pkg::RemW-1:0]    trial;
  logic                         qbit;

  assign in_i.ready      = (state_q == itrt_pkg::ST_IDLE);
  assign in_acc          = in_i.valid && in_i.ready;
  assign emit_go         = (state_q == itrt_pkg::ST_EMIT) && (!out_valid_q || out_o.ready);
  assign more_digits     = ((cnt_q + itrt_pkg::CntW'(1)) < itrt_pkg::CntW'(itrt_pkg::MaxDigits))
                           && (num_q != '0);
  assign trial           = {rem_q[itrt_pkg::RemW-2:0], num_q[itrt_pkg::ValueW-1]};
  assign qbit            = (trial >= radix_q);

  assign out_o.valid     = out_valid_q;
  assign out_o.text_char = out_char_q;
  assign out_o.last      = out_last_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      itrt_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.format == itrt_pkg::FmtCharacter) begin
            state_d = itrt_pkg::ST_EMIT;
          end else begin
            state_d = itrt_pkg::ST_DIV;
          end
        end
      end
      itrt_pkg::ST_DIV: begin
        if (bit_q == itrt_pkg::BitCntW'(itrt_pkg::ValueW - 1)) begin
          state_d = itrt_pkg::ST_DIGIT;
        end
      end
      itrt_pkg::ST_DIGIT: begin
        if (more_digits) begin
          state_d = itrt_pkg::ST_DIV;
        end else if (neg_q) begin
          state_d = itrt_pkg::ST_SIGN;
        end else begin
          state_d = itrt_pkg::ST_EMIT;
        end
      end
      itrt_pkg::ST_SIGN: begin
        state_d = itrt_pkg::ST_EMIT;
      end
      itrt_pkg::ST_EMIT: begin
        if (emit_go && (rd_q == '0)) begin
          state_d = itrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = itrt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    num_d       = num_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    buf_we      = 1'b0;
    buf_wa      = cnt_q[itrt_pkg::IdxW-1:0];
    buf_wd      = itrt_pkg::digit_glyph(rem_q[3:0]);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      itrt_pkg::ST_IDLE: begin
        if (in_acc) begin
          rem_d = '0;
          bit_d = '0;
          if (in_i.format == itrt_pkg::FmtCharacter) begin
            buf_we = 1'b1;
            buf_wa = '0;
            buf_wd = in_i.value[itrt_pkg::CharW-1:0];
            cnt_d  = itrt_pkg::CntW'(1);
            rd_d   = '0;
            neg_d  = 1'b0;
          end else begin
            cnt_d = '0;
            if (in_i.format == itrt_pkg::FmtSignedDec) begin
              radix_d = itrt_pkg::SignedRadix;
              neg_d   = in_i.value[itrt_pkg::ValueW-1];
              num_d   = in_i.value[itrt_pkg::ValueW-1] ? (~in_i.value + 32'd1) : in_i.value;
            end else begin
              radix_d = (in_i.format > itrt_pkg::RadixLimit) ? itrt_pkg::RadixLimit
                                                              : in_i.format;
              neg_d   = 1'b0;
              num_d   = in_i.value;
            end
          end
        end
      end
      itrt_pkg::ST_DIV: begin
        rem_d = qbit ? (trial - radix_q) : trial;
        num_d = {num_q[itrt_pkg::ValueW-2:0], qbit};
        bit_d = bit_q + itrt_pkg::BitCntW'(1);
      end
      itrt_pkg::ST_DIGIT: begin
        buf_we = 1'b1;
        cnt_d  = cnt_q + itrt_pkg::CntW'(1);
        rd_d   = cnt_q[itrt_pkg::IdxW-1:0];
        rem_d  = '0;
        bit_d  = '0;
      end
      itrt_pkg::ST_SIGN: begin
        buf_we = 1'b1;
        buf_wd = itrt_pkg::MinusChar;
        cnt_d  = cnt_q + itrt_pkg::CntW'(1);
        rd_d   = cnt_q[itrt_pkg::IdxW-1:0];
      end
      itrt_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          out_char_d  = buf_q[rd_q];
          out_last_d  = (rd_q == '0);
          if (rd_q != '0) begin
            rd_d = rd_q - itrt_pkg::IdxW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itrt_pkg::ST_IDLE;
      bit_q       <= '0;
      cnt_q       <= '0;
      rd_q        <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      cnt_q       <= cnt_d;
      rd_q        <= rd_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q      <= num_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_q[buf_wa] <= buf_wd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= itrt_pkg::CntW'(itrt_pkg::BufDepth))
    else $error("Character count exceeds the buffer depth.");

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itrt_pkg::ST_DIGIT) |-> (rem_q < radix_q))
    else $error("Division remainder is not below the radix.");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itrt_pkg::ST_EMIT) |-> (itrt_pkg::CntW'(rd_q) < cnt_q))
    else $error("Emit index points past the stored characters.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("Input ready right after an item was accepted.");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && (rd_q == '0)) |=> (out_valid_q && out_last_q
                                   && (state_q == itrt_pkg::ST_IDLE)))
    else $error("Final character not marked last or sequencer not idle.");

endmodule
